>>> src/blc_pkg.sv
// Shared types and constants for the budgeted slot cache.
// Used by blc_ctrl, blc_dp and budgeted_lru_entry_cache; no dependencies.
`default_nettype none
package blc_pkg;

  // Budget after reset: 96 MiB
  localparam logic [31:0] BUDGET_RESET = 32'd100663296;
  // Four bytes per pixel, applied as a shift
  localparam int unsigned BPP_SHIFT = 2;

  typedef enum logic [2:0] {
    OC_EVICT   = 3'd0,
    OC_STORED  = 3'd1,
    OC_DISCARD = 3'd2,
    OC_HIT     = 3'd3,
    OC_MISS    = 3'd4
  } outcome_t;

  // One slot as held in the slot RAM
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] handle;
    logic [6:0]  frames;
    logic [10:0] width;
    logic [10:0] height;
    logic [31:0] bytes;
    logic [31:0] stamp;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_CHECK,
    ST_SCAN_RD,
    ST_SCAN_CK,
    ST_EV_RD,
    ST_EV_EMIT,
    ST_PLACE,
    ST_DISCARD,
    ST_TK_RD,
    ST_TK_CK,
    ST_TK_HIT,
    ST_TK_MISS
  } ctl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     load_req;
    logic     scan_clr;
    logic     scan_next;
    logic     scan_step;
    logic     rd_en;
    logic     rd_best;
    logic     place;
    logic     release_slot;
    logic     rel_best;
    logic     emit;
    outcome_t oc;
    logic     last;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_take;
    logic key_zero;
    logic store_ok;
    logic need_evict;
    logic any_free;
    logic scan_last;
    logic best_found;
    logic match;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> src/blc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module blc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> src/blc_ctrl.sv
// Sequencer for the budgeted slot cache: drives datapath commands.
// Depends on blc_pkg.
`default_nettype none
module blc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  input  wire blc_pkg::status_t st,
  output blc_pkg::cmd_t         cmd,
  output logic                  idle
);
  import blc_pkg::*;

  ctl_state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.oc    = OC_MISS;
    idle      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_MUL1;
        end
      end
      ST_MUL1: begin
        if (st.is_take) begin
          if (st.key_zero) begin
            state_nxt = ST_TK_MISS;
          end else begin
            cmd.scan_clr = 1'b1;
            state_nxt    = ST_TK_RD;
          end
        end else begin
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!st.store_ok) begin
          state_nxt = ST_DISCARD;
        end else if (st.need_evict) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = ST_SCAN_RD;
        end else begin
          state_nxt = ST_PLACE;
        end
      end
      // Find the oldest valid slot, one slot per read/compare pair
      ST_SCAN_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_SCAN_CK;
      end
      ST_SCAN_CK: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) begin
          state_nxt = ST_EV_RD;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = ST_SCAN_RD;
        end
      end
      ST_EV_RD: begin
        if (st.best_found) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_best = 1'b1;
          state_nxt   = ST_EV_EMIT;
        end else begin
          state_nxt = ST_PLACE;
        end
      end
      ST_EV_EMIT: begin
        if (st.out_free) begin
          cmd.emit         = 1'b1;
          cmd.oc           = OC_EVICT;
          cmd.release_slot = 1'b1;
          cmd.rel_best     = 1'b1;
          state_nxt        = ST_CHECK;
        end
      end
      ST_PLACE: begin
        if (!st.any_free) begin
          state_nxt = ST_DISCARD;
        end else if (st.out_free) begin
          cmd.place = 1'b1;
          cmd.emit  = 1'b1;
          cmd.oc    = OC_STORED;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DISCARD: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.oc    = OC_DISCARD;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      // Take: walk slots in index order, stop at first match
      ST_TK_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_TK_CK;
      end
      ST_TK_CK: begin
        if (st.match) begin
          state_nxt = ST_TK_HIT;
        end else if (st.scan_last) begin
          state_nxt = ST_TK_MISS;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = ST_TK_RD;
        end
      end
      ST_TK_HIT: begin
        if (st.out_free) begin
          cmd.emit         = 1'b1;
          cmd.oc           = OC_HIT;
          cmd.last         = 1'b1;
          cmd.release_slot = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      ST_TK_MISS: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.oc    = OC_MISS;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> src/blc_dp.sv
// Datapath for the budgeted slot cache: request latch, size multiply,
// slot RAM, valid bits, byte and stamp counters, output register.
// Depends on blc_pkg and blc_ram.
`default_nettype none
module blc_dp #(
  parameter int SLOT_COUNT = 32,
  parameter int MAX_FRAMES = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire blc_pkg::cmd_t    cmd,
  output blc_pkg::status_t      st,
  input  wire logic             cfg_fire,
  input  wire logic [31:0]      cfg_budget_bytes,
  input  wire logic             in_func,
  input  wire logic [31:0]      in_entry_key,
  input  wire logic [31:0]      in_set_handle,
  input  wire logic [6:0]       in_frame_total,
  input  wire logic [10:0]      in_pixel_width,
  input  wire logic [10:0]      in_pixel_height,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [2:0]            out_outcome,
  output logic [31:0]           out_handle,
  output logic [6:0]            out_frames,
  output logic [10:0]           out_width,
  output logic [10:0]           out_height,
  output logic                  out_last
);
  import blc_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Request latch
  logic        func_r;
  logic [31:0] key_r, handle_r;
  logic [6:0]  frames_r;
  logic [10:0] w_r, h_r;
  // Size pipeline
  logic [21:0] area_r;
  logic [31:0] size_r;
  // Control state
  logic [31:0]           budget_r, bytes_r, clock_r;
  logic [SLOT_COUNT-1:0] valid_r;
  logic [IDX_W-1:0]      idx_r, best_idx_r;
  logic [31:0]           best_stamp_r;
  logic                  best_found_r;
  logic                  out_valid_r, out_last_r;
  outcome_t              out_oc_r;
  logic [31:0]           out_handle_r;
  logic [6:0]            out_frames_r;
  logic [10:0]           out_w_r, out_h_r;

  logic [IDX_W-1:0] ff_idx, rd_addr, rel_idx;
  slot_t            rd_slot, wr_slot;
  logic             out_free;
  logic             cur_valid;

  // Latch the request beat
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      func_r   <= in_func;
      key_r    <= in_entry_key;
      handle_r <= in_set_handle;
      frames_r <= in_frame_total;
      w_r      <= in_pixel_width;
      h_r      <= in_pixel_height;
    end
  end

  // Size: width times height, then times frames and bytes per pixel
  always_ff @(posedge clk) begin
    area_r <= 22'((w_r == '0) ? 11'd1 : w_r) * 22'((h_r == '0) ? 11'd1 : h_r);
    size_r <= 32'(29'(area_r) * 29'(frames_r)) << BPP_SHIFT;
  end

  // Lowest free slot
  always_comb begin
    ff_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!valid_r[i]) ff_idx = IDX_W'(i);
    end
  end

  assign rd_addr   = cmd.rd_best ? best_idx_r : idx_r;
  assign rel_idx   = cmd.rel_best ? best_idx_r : idx_r;
  assign cur_valid = valid_r[idx_r];

  always_comb begin
    wr_slot.key    = key_r;
    wr_slot.handle = handle_r;
    wr_slot.frames = frames_r;
    wr_slot.width  = w_r;
    wr_slot.height = h_r;
    wr_slot.bytes  = size_r;
    wr_slot.stamp  = clock_r + 32'd1;
  end

  blc_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.place),
    .waddr (ff_idx),
    .wdata (wr_slot),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_slot)
  );

  // Budget register, valid bits, byte and stamp counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_RESET;
      bytes_r  <= '0;
      clock_r  <= '0;
      valid_r  <= '0;
    end else begin
      if (cfg_fire) begin
        budget_r <= cfg_budget_bytes;
      end
      if (cmd.place) begin
        valid_r[ff_idx] <= 1'b1;
        bytes_r         <= bytes_r + size_r;
        clock_r         <= clock_r + 32'd1;
      end else if (cmd.release_slot) begin
        valid_r[rel_idx] <= 1'b0;
        bytes_r          <= (bytes_r >= rd_slot.bytes) ? bytes_r - rd_slot.bytes : '0;
      end
    end
  end

  // Scan index and oldest-slot tracker
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      idx_r        <= '0;
      best_found_r <= 1'b0;
    end else begin
      if (cmd.scan_step && cur_valid &&
          (!best_found_r || rd_slot.stamp < best_stamp_r)) begin
        best_found_r <= 1'b1;
        best_idx_r   <= idx_r;
        best_stamp_r <= rd_slot.stamp;
      end
      if (cmd.scan_next) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // Output register: load a result beat when the slot is free
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_oc_r   <= cmd.oc;
      out_last_r <= cmd.last;
      case (cmd.oc)
        OC_EVICT, OC_HIT: begin
          out_handle_r <= rd_slot.handle;
          out_frames_r <= rd_slot.frames;
          out_w_r      <= rd_slot.width;
          out_h_r      <= rd_slot.height;
        end
        OC_STORED, OC_DISCARD: begin
          out_handle_r <= handle_r;
          out_frames_r <= frames_r;
          out_w_r      <= w_r;
          out_h_r      <= h_r;
        end
        default: begin
          out_handle_r <= '0;
          out_frames_r <= '0;
          out_w_r      <= '0;
          out_h_r      <= '0;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_outcome = out_oc_r;
  assign out_handle  = out_handle_r;
  assign out_frames  = out_frames_r;
  assign out_width   = out_w_r;
  assign out_height  = out_h_r;
  assign out_last    = out_last_r;

  // Status back to the controller
  always_comb begin
    st.is_take    = func_r;
    st.key_zero   = (key_r == '0);
    st.store_ok   = (key_r != '0) && (frames_r != '0) &&
                    (frames_r <= 7'(MAX_FRAMES)) && (size_r <= budget_r);
    st.any_free   = ~&valid_r;
    st.need_evict = ({1'b0, bytes_r} + {1'b0, size_r} > {1'b0, budget_r}) ||
                    !st.any_free;
    st.scan_last  = (idx_r == IDX_W'(SLOT_COUNT - 1));
    st.best_found = best_found_r;
    st.match      = cur_valid && (rd_slot.key == key_r);
    st.out_free   = out_free;
  end
endmodule
`default_nettype wire

>>> src/budgeted_lru_entry_cache.sv
// Budgeted slot cache, top level: joins blc_ctrl and blc_dp.
// Store: latch, size multiply and check, then per eviction a stamp scan through the
// single slot RAM read port, read, emit and recheck; then place.
// Take: a read and a compare per slot walked, in index order. One request at a time.
// Reset (sync, active low): budget 96 MiB, all slots invalid, counters zero;
// no clearing pass, ready as soon as reset is released.
`default_nettype none
module budgeted_lru_entry_cache #(
  parameter int SLOT_COUNT = 32,
  parameter int MAX_FRAMES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_budget_bytes,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [31:0] in_entry_key,
  input  wire logic [31:0] in_set_handle,
  input  wire logic [6:0]  in_frame_total,
  input  wire logic [10:0] in_pixel_width,
  input  wire logic [10:0] in_pixel_height,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_outcome,
  output logic [31:0]      out_handle,
  output logic [6:0]       out_frames,
  output logic [10:0]      out_width,
  output logic [10:0]      out_height,
  output logic             out_last
);
  import blc_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    idle;

  // Take a request beat only when the sequencer is idle
  assign in_stall  = !idle;
  assign cfg_ready = 1'b1;

  blc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_valid && idle),
    .st      (st),
    .cmd     (cmd),
    .idle    (idle)
  );

  blc_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .cfg_fire         (cfg_valid && cfg_ready),
    .cfg_budget_bytes (cfg_budget_bytes),
    .in_func          (in_func),
    .in_entry_key     (in_entry_key),
    .in_set_handle    (in_set_handle),
    .in_frame_total   (in_frame_total),
    .in_pixel_width   (in_pixel_width),
    .in_pixel_height  (in_pixel_height),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_outcome      (out_outcome),
    .out_handle       (out_handle),
    .out_frames       (out_frames),
    .out_width        (out_width),
    .out_height       (out_height),
    .out_last         (out_last)
  );
endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking bench for budgeted_lru_entry_cache: directed and random store/take
// requests, budget writes between phases, in-order check of every result beat.
// Depends on blc_pkg and the cache RTL.
`default_nettype none
module testbench;
  import blc_pkg::*;

  localparam int NSLOT = 32;
  localparam int MAXF  = 64;

  typedef struct packed {
    logic        func;
    logic [31:0] key;
    logic [31:0] handle;
    logic [6:0]  frames;
    logic [10:0] width;
    logic [10:0] height;
  } req_t;

  typedef struct packed {
    outcome_t    oc;
    logic [31:0] handle;
    logic [6:0]  frames;
    logic [10:0] width;
    logic [10:0] height;
    logic        last;
  } res_t;

  logic clk = 0, rst_n = 0;
  logic cfg_valid = 0;
  logic [31:0] cfg_budget_bytes = '0;
  logic cfg_ready;
  logic in_valid = 0, in_stall;
  logic in_func = 0;
  logic [31:0] in_entry_key = '0, in_set_handle = '0;
  logic [6:0] in_frame_total = '0;
  logic [10:0] in_pixel_width = '0, in_pixel_height = '0;
  logic out_valid, out_stall = 0, out_last;
  logic [2:0] out_outcome;
  logic [31:0] out_handle;
  logic [6:0] out_frames;
  logic [10:0] out_width, out_height;

  budgeted_lru_entry_cache DUT (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_budget_bytes,
    .in_valid, .in_stall, .in_func, .in_entry_key, .in_set_handle,
    .in_frame_total, .in_pixel_width, .in_pixel_height,
    .out_valid, .out_stall, .out_outcome, .out_handle, .out_frames,
    .out_width, .out_height, .out_last
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Shadow cache state
  logic [31:0] sh_key [NSLOT];
  logic [31:0] sh_handle [NSLOT];
  logic [6:0]  sh_frames [NSLOT];
  logic [10:0] sh_width [NSLOT];
  logic [10:0] sh_height [NSLOT];
  logic [31:0] sh_bytes [NSLOT];
  logic [31:0] sh_stamp [NSLOT];
  logic        sh_valid [NSLOT];
  logic [31:0] sh_in_use, sh_clock, sh_budget;

  req_t pending_reqs [$];
  res_t expected_beats [$];
  int errors = 0;
  logic hold_start = 0;
  logic long_hold = 0;
  logic feed_done = 0;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int lowest_open_slot();
    for (int i = 0; i < NSLOT; i++) if (!sh_valid[i]) return i;
    return -1;
  endfunction

  function automatic void drop_slot(input int i);
    if (sh_in_use >= sh_bytes[i]) sh_in_use -= sh_bytes[i];
    else sh_in_use = 0;
    sh_valid[i] = 0;
  endfunction

  function automatic void push_beat(input outcome_t oc, input logic [31:0] h,
                                    input logic [6:0] f, input logic [10:0] w,
                                    input logic [10:0] ht, input logic lst);
    res_t r;
    r = '{oc, h, f, w, ht, lst};
    expected_beats.push_back(r);
  endfunction

  // Predict the beats of one accepted request and update the shadow cache
  function automatic void predict_cache(input req_t q);
    logic [63:0] sz;
    int slot, old;
    if (q.func) begin
      if (q.key != 0)
        for (int i = 0; i < NSLOT; i++)
          if (sh_valid[i] && sh_key[i] == q.key) begin
            push_beat(OC_HIT, sh_handle[i], sh_frames[i], sh_width[i], sh_height[i], 1'b1);
            drop_slot(i);
            return;
          end
      push_beat(OC_MISS, '0, '0, '0, '0, 1'b1);
      return;
    end
    sz = 64'(q.width ? q.width : 11'd1) * 64'(q.height ? q.height : 11'd1) * 4 * q.frames;
    if (q.key != 0 && q.frames != 0 && q.frames <= MAXF && sz <= sh_budget) begin
      while (64'(sh_in_use) + sz > sh_budget || lowest_open_slot() < 0) begin
        old = -1;
        for (int i = 0; i < NSLOT; i++)
          if (sh_valid[i] && (old < 0 || sh_stamp[i] < sh_stamp[old])) old = i;
        if (old < 0) break;
        push_beat(OC_EVICT, sh_handle[old], sh_frames[old], sh_width[old],
                  sh_height[old], 1'b0);
        drop_slot(old);
      end
      slot = lowest_open_slot();
      if (slot >= 0) begin
        sh_key[slot] = q.key; sh_handle[slot] = q.handle;
        sh_frames[slot] = q.frames; sh_width[slot] = q.width;
        sh_height[slot] = q.height; sh_bytes[slot] = sz[31:0];
        sh_clock = sh_clock + 32'd1;
        sh_stamp[slot] = sh_clock; sh_valid[slot] = 1;
        sh_in_use = sh_in_use + sz[31:0];
        push_beat(OC_STORED, q.handle, q.frames, q.width, q.height, 1'b1);
        return;
      end
    end
    push_beat(OC_DISCARD, q.handle, q.frames, q.width, q.height, 1'b1);
  endfunction

  // Driver: offer queued requests with random gaps
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_cache({in_func, in_entry_key, in_set_handle, in_frame_total,
                       in_pixel_width, in_pixel_height});
        in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0 || pending_reqs.size() == 0) begin
          in_valid <= 0;
          if (in_gap > 0) in_gap--;
        end else begin
          req_t q;
          q = pending_reqs.pop_front();
          in_valid <= 1;
          {in_func, in_entry_key, in_set_handle, in_frame_total,
           in_pixel_width, in_pixel_height} <= q;
        end
      end
    end
  end

  // Long receiver hold-off, counted here once requested
  initial begin
    wait (hold_start);
    @(posedge clk);
    long_hold <= 1;
    repeat (300) @(posedge clk);
    long_hold <= 0;
  end

  // Monitor: check each result beat and draw receiver stalls
  int out_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        res_t e;
        if (expected_beats.size() == 0) report("result beat with nothing expected");
        else begin
          e = expected_beats.pop_front();
          if (out_outcome !== e.oc)
            report($sformatf("outcome %0d, want %0d", out_outcome, e.oc));
          if (out_handle !== e.handle)
            report($sformatf("handle %h, want %h", out_handle, e.handle));
          if (out_frames !== e.frames)
            report($sformatf("frames %0d, want %0d", out_frames, e.frames));
          if (out_width !== e.width)
            report($sformatf("width %0d, want %0d", out_width, e.width));
          if (out_height !== e.height)
            report($sformatf("height %0d, want %0d", out_height, e.height));
          if (out_last !== e.last)
            report($sformatf("last %b, want %b", out_last, e.last));
        end
        out_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
      end
      if (long_hold) begin
        out_stall <= 1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1;
      end else out_stall <= 0;
    end
  end

  task automatic add_req(input logic f, input logic [31:0] k, input logic [31:0] h,
                         input logic [6:0] fr, input logic [10:0] w,
                         input logic [10:0] ht);
    req_t q;
    q = '{f, k, h, fr, w, ht};
    pending_reqs.push_back(q);
  endtask

  task automatic write_budget(input logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_budget_bytes <= v;
    do @(posedge clk); while (!cfg_ready);
    sh_budget = v;
    cfg_valid <= 0;
  endtask

  // Wait until every request has been sent and every beat checked
  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_beats.size() != 0);
    repeat (100) @(posedge clk);
  endtask

  // Random phase: small keys so takes hit, small sizes mostly
  task automatic random_phase(input int n);
    logic [10:0] w, ht;
    for (int i = 0; i < n; i++) begin
      w = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 16));
      ht = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 16));
      if ($urandom_range(0, 19) == 0)
        add_req(1'($urandom_range(0, 1)), $urandom, $urandom, 7'($urandom),
                11'($urandom), 11'($urandom));
      else
        add_req($urandom_range(0, 2) == 0, $urandom_range(0, 12), $urandom,
                ($urandom_range(0, 15) == 0) ? 7'($urandom_range(64, 127))
                                             : 7'($urandom_range(0, 64)), w, ht);
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) sh_valid[i] = 0;
    sh_in_use = 0; sh_clock = 0; sh_budget = BUDGET_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1;

    // Directed: discards, extremes, hits, misses, duplicates
    add_req(0, 0, 32'h1111_1111, 1, 1, 1);
    add_req(0, 5, 32'h2222_2222, 0, 1, 1);
    add_req(0, 5, 32'h3333_3333, 65, 1, 1);
    add_req(0, 5, 32'h4444_4444, 127, 2047, 2047);
    add_req(0, 5, 32'hFFFF_FFFF, 64, 2047, 2047);
    add_req(0, 32'hFFFF_FFFF, 32'h0, 1, 0, 0);
    add_req(0, 7, 32'hA5A5_A5A5, 64, 1024, 256);
    add_req(0, 7, 32'h5A5A_5A5A, 2, 3, 0);
    add_req(1, 7, 32'hDEAD_BEEF, 9, 9, 9);
    add_req(1, 7, 0, 0, 0, 0);
    add_req(1, 7, 0, 0, 0, 0);
    add_req(1, 0, 0, 0, 0, 0);
    add_req(1, 32'hFFFF_FFFF, 0, 0, 0, 0);
    for (int i = 0; i < 34; i++) add_req(0, 100 + i, i, 1, 1, 1);
    drain();

    // Lowered budget: a big store evicts every slot
    write_budget(32'd64);
    add_req(0, 9, 32'hCAFE_0001, 16, 1, 1);
    add_req(0, 9, 32'hCAFE_0002, 1, 2, 2);
    drain();
    write_budget(32'd0);
    add_req(0, 9, 32'hCAFE_0003, 1, 1, 1);
    drain();
    write_budget(32'hFFFF_FFFF);
    random_phase(15);
    drain();
    write_budget(32'd2048);
    random_phase(15);
    // Long receiver hold-off while requests keep coming
    hold_start = 1;
    random_phase(15);
    drain();
    write_budget(BUDGET_RESET);
    random_phase(10);
    drain();
    feed_done = 1;
  end

  initial begin
    wait (feed_done);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    #20000000;
    $display("testbench: errors");
    $finish;
  end
endmodule
`default_nettype wire
